// File: rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PAYLOAD_LEN  = 4;
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'h55;

    // Report as carried on the result channel: x1 in the lowest byte.
    typedef struct packed {
        logic        [BYTE_W-1:0] button_bits;
        logic signed [BYTE_W-1:0] stick_x2;
        logic signed [BYTE_W-1:0] stick_y1;
        logic signed [BYTE_W-1:0] stick_x1;
    } report_t;

    // A completed frame whose checksum matched, from parser to filter.
    typedef struct packed {
        logic    ok;
        report_t report;
    } frame_t;

    // A report to be delivered, from filter to output stage.
    typedef struct packed {
        logic    valid;
        report_t report;
    } result_t;

endpackage

// File: rtl/sfr_frame_parser.sv
module sfr_frame_parser
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_fire,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] sync_byte,
    output frame_t            frame
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_X1    = 3'd1,
        PH_Y1    = 3'd2,
        PH_X2    = 3'd3,
        PH_BTN   = 3'd4,
        PH_CK_LO = 3'd5,
        PH_CK_HI = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_LEN];
    logic [BYTE_W-1:0] ck_low_reg;
    logic [15:0]       ck_expected;
    logic [15:0]       ck_received;

    assign ck_expected = {payload_reg[0], payload_reg[1]} ^ {payload_reg[2], payload_reg[3]};
    assign ck_received = {rx_byte, ck_low_reg};

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:  phase_next = (rx_byte == sync_byte) ? PH_X1 : PH_HUNT;
            PH_X1:    phase_next = PH_Y1;
            PH_Y1:    phase_next = PH_X2;
            PH_X2:    phase_next = PH_BTN;
            PH_BTN:   phase_next = PH_CK_LO;
            PH_CK_LO: phase_next = PH_CK_HI;
            PH_CK_HI: phase_next = PH_HUNT;
            default:  phase_next = (rx_byte == sync_byte) ? PH_X1 : PH_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else if (beat_fire) begin
            phase_reg <= phase_next;
        end
    end

    // Payload and checksum capture: no reset, always written before read.
    always_ff @(posedge aclk) begin
        if (beat_fire) begin
            case (phase_reg)
                PH_X1:    payload_reg[0] <= rx_byte;
                PH_Y1:    payload_reg[1] <= rx_byte;
                PH_X2:    payload_reg[2] <= rx_byte;
                PH_BTN:   payload_reg[3] <= rx_byte;
                PH_CK_LO: ck_low_reg     <= rx_byte;
                default:  ;
            endcase
        end
    end

    assign frame.ok                 = beat_fire && (phase_reg == PH_CK_HI)
                                      && (ck_received == ck_expected);
    assign frame.report.stick_x1    = payload_reg[0];
    assign frame.report.stick_y1    = payload_reg[1];
    assign frame.report.stick_x2    = payload_reg[2];
    assign frame.report.button_bits = payload_reg[3];

endmodule

// File: rtl/sfr_change_filter.sv
module sfr_change_filter
    import sfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  frame_t  frame,
    output result_t result
);

    report_t last_report_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_report_reg <= '0;
        end else if (frame.ok) begin
            last_report_reg <= frame.report;
        end
    end

    assign result.valid  = frame.ok && (frame.report != last_report_reg);
    assign result.report = frame.report;

`ifndef SYNTHESIS
    a_stored_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |=> last_report_reg == $past(frame.report))
        else $error("stored report not updated after emit");

    a_unchanged_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame.ok && !result.valid) |=> $stable(last_report_reg))
        else $error("stored report moved on an unchanged frame");
`endif

endmodule

// File: rtl/sfr_out_skid.sv
module sfr_out_skid
    import sfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    beat_fire,
    input  result_t result,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output report_t m_report
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    report_t main_reg;
    report_t skid_reg;
    logic    push;
    logic    pop;

    assign push = beat_fire && result.valid;
    assign pop  = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= result.report;
            end else begin
                main_reg <= result.report;
            end
        end
    end

    assign room     = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_report = main_reg;

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with the main stage empty");
`endif

endmodule

// File: rtl/sync_frame_receiver_change_filter.sv
// A frame's report is registered into the output stage on its last checksum beat.
// Throughput: one byte per cycle; the two-entry output stage stalls input only once
//   two reports wait on a stalled result channel.
// Reset: synchronous, active low on aresetn; hunts for sync, stored report all zeros,
//   sync byte 0x55, output stage empty.
module sync_frame_receiver_change_filter
    import sfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // reports
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] stick_x1, [15:8] stick_y1,
                                   // [23:16] stick_x2, [31:24] button_bits
    // sync byte register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic              beat_fire;
    logic              room;
    logic [BYTE_W-1:0] sync_byte_reg;
    frame_t            frame;
    result_t           result;
    report_t           m_report;

    // Take the sync byte register at any time; users must write it only while idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_BYTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            sync_byte_reg <= cfg_data;
        end
    end

    // Accept a byte whenever the output stage can still absorb a report.
    assign s_tready  = room;
    assign beat_fire = s_tvalid && s_tready;

    // Track frame phase, capture payload and check the checksum on the last beat.
    sfr_frame_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .rx_byte   (s_tdata),
        .sync_byte (sync_byte_reg),
        .frame     (frame)
    );

    // Drop frames equal to the stored report; update the store on every good frame.
    sfr_change_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .frame   (frame),
        .result  (result)
    );

    // Hold reports for the result channel; the skid entry absorbs a stalled beat.
    sfr_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .result    (result),
        .room      (room),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_report  (m_report)
    );

    assign m_tdata = m_report;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench
    import sfr_pkg::*;
;

    localparam int RUN_LIMIT   = 400000;  // cycles before the run is declared hung
    localparam int HOLD_CYCLES = 300;     // length of the long result-side hold-off
    localparam int DRAIN_GAP   = 8;       // cycles the block may still be busy after a report

    // Receive-side phase tracking, mirrors the frame layout on the link
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_X1,
        PH_Y1,
        PH_X2,
        PH_BUTTONS,
        PH_CK_LOW,
        PH_CK_HIGH
    } frame_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [7:0] stick_x1, [15:8] stick_y1,
                             // [23:16] stick_x2, [31:24] button_bits
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Frame tracker state: what the receiver ought to hold after each accepted beat
    logic [7:0]   sync_value;
    frame_phase_t rx_phase;
    logic [7:0]   rx_payload [4];
    logic [7:0]   rx_ck_low;
    report_t      held_report;
    report_t      expected_reports [$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_requested;
    int hold_served;
    int hold_left;
    int fail_count;
    int cycle_count;

    sync_frame_receiver_change_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[sync_frame_receiver_change_filter] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requested) begin
            hold_served <= hold_requested;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare every report beat against the oldest outstanding expectation
    always @(posedge aclk) begin : check_reports
        report_t got;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = report_t'(m_tdata);
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %h", $time, got);
                fail_count <= fail_count + 1;
            end else begin
                want = expected_reports.pop_front();
                if (got.stick_x1 !== want.stick_x1 || got.stick_y1 !== want.stick_y1 ||
                    got.stick_x2 !== want.stick_x2 || got.button_bits !== want.button_bits) begin
                    $display("%0t: report mismatch, expected %h, got %h", $time, want, got);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Advance the frame tracker by one accepted byte; queue a report when a frame
    // passes its checksum and differs from the stored report
    task automatic track_byte(input logic [7:0] b);
        logic [15:0] sum_calc;
        report_t     frame_rep;
        case (rx_phase)
            PH_X1: begin
                rx_payload[0] = b;
                rx_phase = PH_Y1;
            end
            PH_Y1: begin
                rx_payload[1] = b;
                rx_phase = PH_X2;
            end
            PH_X2: begin
                rx_payload[2] = b;
                rx_phase = PH_BUTTONS;
            end
            PH_BUTTONS: begin
                rx_payload[3] = b;
                rx_phase = PH_CK_LOW;
            end
            PH_CK_LOW: begin
                rx_ck_low = b;
                rx_phase = PH_CK_HIGH;
            end
            PH_CK_HIGH: begin
                rx_phase  = PH_HUNT;
                frame_rep = {rx_payload[3], rx_payload[2], rx_payload[1], rx_payload[0]};
                sum_calc  = {rx_payload[0], rx_payload[1]} ^ {rx_payload[2], rx_payload[3]};
                if ({b, rx_ck_low} == sum_calc && frame_rep != held_report) begin
                    held_report = frame_rep;
                    expected_reports.push_back(frame_rep);
                end
            end
            default: rx_phase = (b == sync_value) ? PH_X1 : PH_HUNT;
        endcase
    endtask

    // Offer one byte, idling first at random; leaves tvalid high for the next beat
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        track_byte(b);
    endtask

    task automatic send_frame(input report_t rep, input bit corrupt);
        logic [15:0] ck;
        ck = {rep.stick_x1, rep.stick_y1} ^ {rep.stick_x2, rep.button_bits};
        if (corrupt)
            ck = ck ^ 16'($urandom_range(1, 16'hFFFF));
        send_byte(sync_value);
        send_byte(rep.stick_x1);
        send_byte(rep.stick_y1);
        send_byte(rep.stick_x2);
        send_byte(rep.button_bits);
        send_byte(ck[7:0]);
        send_byte(ck[15:8]);
    endtask

    // Random payload, with the sync value slipped into some bytes
    function automatic report_t random_report();
        logic [7:0] pb [4];
        for (int i = 0; i < 4; i++)
            pb[i] = ($urandom_range(0, 99) < 12) ? sync_value : 8'($urandom);
        return {pb[3], pb[2], pb[1], pb[0]};
    endfunction

    // Finish any partial frame, drop tvalid and wait until every report is out
    task automatic drain_frames();
        while (rx_phase != PH_HUNT)
            send_byte(8'($urandom));
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    task automatic test_directed();
        report_t rep;
        send_byte(8'h00);                   // noise while hunting
        send_frame('0, 1'b0);               // equals the reset report: no beat
        // extremes of stick_x1, stick_y1 and button_bits, sync value carried as stick_x2 data
        rep.stick_x1    = 8'h7F;
        rep.stick_y1    = 8'h80;
        rep.stick_x2    = sync_value;
        rep.button_bits = 8'hFF;
        send_frame(rep, 1'b0);
        // bad checksum on a fresh report: dropped
        rep.stick_x1    = 8'hFF;
        rep.stick_y1    = 8'h80;
        rep.stick_x2    = 8'h7F;
        rep.button_bits = 8'h00;
        send_frame(rep, 1'b1);
    endtask

    task automatic test_sync_register(input logic [7:0] value);
        drain_frames();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        sync_value = value;
    endtask

    task automatic test_random_traffic(input int frames);
        int pick;
        repeat (frames) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // line noise, sometimes hitting the sync value
                repeat ($urandom_range(1, 3))
                    send_byte(($urandom_range(0, 3) == 0) ? sync_value : 8'($urandom));
            end else if (pick < 18) begin
                send_frame(random_report(), 1'b1);
            end else if (pick < 30) begin
                send_frame(held_report, 1'b0);      // unchanged report
            end else if (pick < 38) begin
                // cut-off frame: the next sync lands inside it as data
                send_byte(sync_value);
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom));
            end else begin
                send_frame(random_report(), 1'b0);
            end
        end
    endtask

    // Hold the result side off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        hold_requested = hold_requested + 1;
        repeat (12)
            send_frame(random_report(), 1'b0);
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        m_tready       <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        fail_count     = 0;
        cycle_count    = 0;
        hold_requested = 0;
        hold_served    = 0;
        hold_left      = 0;
        sync_value     = SYNC_BYTE_RESET;
        rx_phase       = PH_HUNT;
        rx_ck_low      = '0;
        held_report    = '0;
        for (int i = 0; i < 4; i++)
            rx_payload[i] = '0;
        set_idling(15, 68);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_sync_register(8'hFF);
        test_random_traffic(90);

        set_idling(68, 15);
        test_sync_register(8'h00);
        test_random_traffic(90);

        set_idling(0, 0);
        test_sync_register(8'($urandom));
        test_random_traffic(70);
        test_backpressure();
        test_sync_register(SYNC_BYTE_RESET);
        test_random_traffic(10);

        drain_frames();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[sync_frame_receiver_change_filter] OK");
        end else begin
            $display("[sync_frame_receiver_change_filter] ERROR");
        end
        $finish;
    end

endmodule
